>>> sv/base64url_decoder_macros.svh
// Assertion macros for the decoder modules; only b64d_back includes them.
// Every macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef BASE64URL_DECODER_MACROS_SVH
`define BASE64URL_DECODER_MACROS_SVH

// The condition must never hold.
`define B64D_ASSERT_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define B64D_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> sv/b64d_pkg.sv
`timescale 1ns / 1ps

package b64d_pkg;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_BAD_CHAR   = 2'd1,
		ST_LONE_FINAL = 2'd2,
		ST_LEFTOVER   = 2'd3
	} status_t;

	// Alphabet selection codes.
	localparam logic ALPHA_STANDARD = 1'b0;
	localparam logic ALPHA_URL      = 1'b1;

	// A classified character as it travels from the front to the back.
	typedef struct packed {
		logic [5:0] sextet;
		logic       bad;
		logic       last;
	} item_t;

	// One result item.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_message;
		status_t    status;
	} result_t;

endpackage

>>> sv/base64url_decoder.sv
`timescale 1ns / 1ps
// Unpadded base64 / base64url decoder, one character per transfer.
// Throughput: one character per cycle while neither queue is full; at most one result per character.
// A character is registered in the character queue, decoded combinationally, and its
// result is registered in the result queue, from which it can then be popped.
// Reset (arst_n low, asynchronous): both queues empty, group state cleared, url alphabet.
module base64url_decoder #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_in,
	input  logic       is_last,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] data_byte,
	output logic       byte_valid,
	output logic       end_of_message,
	output logic [1:0] status,
	input  logic       cfg_we,
	input  logic       cfg_wdata
);

	localparam int unsigned ITEM_W = $bits(b64d_pkg::item_t);
	localparam int unsigned RES_W  = $bits(b64d_pkg::result_t);

	logic              alphabet_select_q;
	b64d_pkg::item_t   front_item;
	b64d_pkg::item_t   back_item;
	logic              mid_empty;
	logic              item_pop;
	logic              res_full;
	logic              res_push;
	b64d_pkg::result_t back_res;
	b64d_pkg::result_t out_res;

	// Alphabet select register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alphabet_select_q <= b64d_pkg::ALPHA_URL;
		end else if (cfg_we) begin
			alphabet_select_q <= cfg_wdata;
		end
	end

	// Front: classify the character as it is accepted.
	b64d_front u_front (
		.char_in         (char_in),
		.is_last         (is_last),
		.alphabet_select (alphabet_select_q),
		.item            (front_item)
	);

	// Queue between the front and the decode step.
	b64d_fifo #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (ITEM_W)
	) u_char_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_item),
		.full   (full),
		.pop    (item_pop),
		.rdata  (back_item),
		.empty  (mid_empty)
	);

	// Back: group state and byte assembly.
	b64d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_avail (!mid_empty),
		.item       (back_item),
		.item_pop   (item_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (back_res)
	);

	// Result queue toward the consumer.
	b64d_fifo #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (RES_W)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (back_res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (out_res),
		.empty  (empty)
	);

	assign data_byte      = out_res.data_byte;
	assign byte_valid     = out_res.byte_valid;
	assign end_of_message = out_res.end_of_message;
	assign status         = 2'(out_res.status);

endmodule

>>> sv/b64d_fifo.sv
`timescale 1ns / 1ps

module b64d_fifo #(
	parameter int unsigned DEPTH = 2,
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	// A transfer happens only on the side that has room or data.
	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = entries_q[rd_ptr_q];

	// Storage; entries need no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> sv/b64d_front.sv
`timescale 1ns / 1ps

module b64d_front (
	input  logic            [7:0] char_in,
	input  logic                  is_last,
	input  logic                  alphabet_select,
	output b64d_pkg::item_t       item
);

	logic [5:0] sextet;
	logic       bad;

	// Map the character to its 6-bit value under the selected alphabet.
	always_comb begin
		sextet = '0;
		bad    = 1'b0;
		if (char_in inside {[8'h41:8'h5A]}) begin
			sextet = 6'(char_in - 8'h41);
		end else if (char_in inside {[8'h61:8'h7A]}) begin
			sextet = 6'(char_in - 8'h61 + 8'd26);
		end else if (char_in inside {[8'h30:8'h39]}) begin
			sextet = 6'(char_in - 8'h30 + 8'd52);
		end else if (alphabet_select == b64d_pkg::ALPHA_URL) begin
			case (char_in)
				8'h2D:   sextet = 6'd62;
				8'h5F:   sextet = 6'd63;
				default: bad = 1'b1;
			endcase
		end else begin
			case (char_in)
				8'h2B:   sextet = 6'd62;
				8'h2F:   sextet = 6'd63;
				default: bad = 1'b1;
			endcase
		end
	end

	assign item.sextet = sextet;
	assign item.bad    = bad;
	assign item.last   = is_last;

endmodule

>>> sv/b64d_back.sv
`timescale 1ns / 1ps
`include "base64url_decoder_macros.svh"

module b64d_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_avail,
	input  b64d_pkg::item_t   item,
	output logic              item_pop,
	input  logic              res_full,
	output logic              res_push,
	output b64d_pkg::result_t res
);

	logic [1:0] group_position_q;
	logic [7:0] leftover_bits_q;
	logic       dropping_q;

	logic [1:0] pos_next;
	logic [7:0] left_next;
	logic       drop_next;
	logic [7:0] byte_val;
	logic [7:0] left_after;
	logic       emit;

	// Take the next character whenever the result queue has room.
	assign item_pop = item_avail && !res_full;

	// Decode step for one character.
	always_comb begin
		pos_next   = group_position_q;
		left_next  = leftover_bits_q;
		drop_next  = dropping_q;
		byte_val   = '0;
		left_after = '0;
		emit       = 1'b0;
		res        = '{data_byte: 8'd0, byte_valid: 1'b0, end_of_message: 1'b1,
			status: b64d_pkg::ST_OK};
		if (dropping_q) begin
			if (item.last) begin
				drop_next = 1'b0;
			end
		end else if (item.bad) begin
			emit       = 1'b1;
			res.status = b64d_pkg::ST_BAD_CHAR;
			pos_next   = '0;
			left_next  = '0;
			drop_next  = !item.last;
		end else if (group_position_q == 2'd0) begin
			if (item.last) begin
				emit       = 1'b1;
				res.status = b64d_pkg::ST_LONE_FINAL;
				pos_next   = '0;
				left_next  = '0;
			end else begin
				pos_next  = 2'd1;
				left_next = {item.sextet, 2'b00};
			end
		end else begin
			// Join the leftover bits with the top of the new sextet.
			case (group_position_q)
				2'd1: begin
					byte_val   = leftover_bits_q | {6'b000000, item.sextet[5:4]};
					left_after = {item.sextet[3:0], 4'b0000};
				end
				2'd2: begin
					byte_val   = leftover_bits_q | {4'b0000, item.sextet[5:2]};
					left_after = {item.sextet[1:0], 6'b000000};
				end
				default: begin
					byte_val   = leftover_bits_q | {2'b00, item.sextet};
					left_after = '0;
				end
			endcase
			emit = 1'b1;
			if (item.last) begin
				pos_next  = '0;
				left_next = '0;
				if (left_after != '0) begin
					res.status = b64d_pkg::ST_LEFTOVER;
				end else begin
					res.data_byte  = byte_val;
					res.byte_valid = 1'b1;
				end
			end else begin
				pos_next           = group_position_q + 2'd1;
				left_next          = left_after;
				res.data_byte      = byte_val;
				res.byte_valid     = 1'b1;
				res.end_of_message = 1'b0;
			end
		end
	end

	assign res_push = item_pop && emit;

	// Decoder state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_position_q <= '0;
			leftover_bits_q  <= '0;
			dropping_q       <= 1'b0;
		end else if (item_pop) begin
			group_position_q <= pos_next;
			leftover_bits_q  <= left_next;
			dropping_q       <= drop_next;
		end
	end

	// Checks on the decode state and the results.
	`B64D_ASSERT_NEVER(a_no_result_dropping, item_pop && dropping_q && res_push,
		"result while dropping")
	`B64D_ASSERT_NEVER(a_err_no_byte, res_push && (res.status != b64d_pkg::ST_OK)
		&& (res.byte_valid || !res.end_of_message), "error result malformed")
	`B64D_ASSERT_NEVER(a_pos0_no_leftover,
		(group_position_q == 2'd0) && (leftover_bits_q != 8'd0), "leftover at group start")
	`B64D_ASSERT_NEVER(a_push_needs_room, res_push && res_full,
		"result pushed into full queue")

endmodule

>>> tb/tb_base64url_decoder.sv
`timescale 1ns / 1ps

module tb_base64url_decoder;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 6;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] char_in = 8'h00;
	logic       is_last = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       end_of_message;
	logic [1:0] status;
	logic       cfg_we = 1'b0;
	logic       cfg_wdata = 1'b0;

	// Decoder state as the testbench sees it.
	logic       alpha_sel = b64d_pkg::ALPHA_URL;
	logic [1:0] grp_pos = 2'd0;
	logic [7:0] carry_bits = 8'h00;
	logic       skipping = 1'b0;

	b64d_pkg::result_t pending_results[$];
	b64d_pkg::result_t oldest_result;
	logic [7:0]        msg_chars[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	int cycles = 0;
	int mismatches = 0;
	int chars_sent = 0;
	int results_seen = 0;
	int errors_flagged = 0;
	int full_stalls = 0;

	base64url_decoder u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.char_in        (char_in),
		.is_last        (is_last),
		.empty          (empty),
		.pop            (pop),
		.data_byte      (data_byte),
		.byte_valid     (byte_valid),
		.end_of_message (end_of_message),
		.status         (status),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata)
	);

	always #10 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles,
				pending_results.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(string msg);
		$display("MISMATCH at cycle %0d: %s", cycles, msg);
		mismatches++;
	endtask

	// An error result clears the group and starts dropping unless the message has ended.
	task automatic post_error(b64d_pkg::status_t st, logic last);
		b64d_pkg::result_t r;
		r.data_byte = 8'h00;
		r.byte_valid = 1'b0;
		r.end_of_message = 1'b1;
		r.status = st;
		pending_results.push_back(r);
		grp_pos = 2'd0;
		carry_bits = 8'h00;
		skipping = !last;
		errors_flagged++;
	endtask

	// Predict what one accepted character produces.
	task automatic decode_char(logic [7:0] c, logic last);
		logic [5:0]        v;
		logic              bad;
		logic [7:0]        out_byte;
		b64d_pkg::result_t r;
		v = 6'd0;
		bad = 1'b0;
		out_byte = 8'h00;
		if (skipping) begin
			if (last)
				skipping = 1'b0;
			return;
		end
		if (c >= "A" && c <= "Z")
			v = 6'(c - "A");
		else if (c >= "a" && c <= "z")
			v = 6'(c - "a" + 26);
		else if (c >= "0" && c <= "9")
			v = 6'(c - "0" + 52);
		else if (alpha_sel == b64d_pkg::ALPHA_URL && c == "-")
			v = 6'd62;
		else if (alpha_sel == b64d_pkg::ALPHA_URL && c == "_")
			v = 6'd63;
		else if (alpha_sel == b64d_pkg::ALPHA_STANDARD && c == "+")
			v = 6'd62;
		else if (alpha_sel == b64d_pkg::ALPHA_STANDARD && c == "/")
			v = 6'd63;
		else
			bad = 1'b1;
		if (bad) begin
			post_error(b64d_pkg::ST_BAD_CHAR, last);
			return;
		end
		case (grp_pos)
			2'd0: begin
				if (last) begin
					post_error(b64d_pkg::ST_LONE_FINAL, 1'b1);
				end else begin
					carry_bits = {v, 2'b00};
					grp_pos = 2'd1;
				end
				return;
			end
			2'd1: begin
				out_byte = carry_bits | {6'b000000, v[5:4]};
				carry_bits = {v[3:0], 4'b0000};
				grp_pos = 2'd2;
			end
			2'd2: begin
				out_byte = carry_bits | {4'b0000, v[5:2]};
				carry_bits = {v[1:0], 6'b000000};
				grp_pos = 2'd3;
			end
			default: begin
				out_byte = carry_bits | {2'b00, v};
				carry_bits = 8'h00;
				grp_pos = 2'd0;
			end
		endcase
		if (last && carry_bits != 8'h00) begin
			post_error(b64d_pkg::ST_LEFTOVER, 1'b1);
			return;
		end
		if (last) begin
			grp_pos = 2'd0;
			carry_bits = 8'h00;
		end
		r.data_byte = out_byte;
		r.byte_valid = 1'b1;
		r.end_of_message = last;
		r.status = b64d_pkg::ST_OK;
		pending_results.push_back(r);
	endtask

	// Offer one character; push stays high afterwards so back-to-back transfers have no gap.
	task automatic send_char(logic [7:0] c, logic last);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		char_in <= c;
		is_last <= last;
		@(posedge clk);
		while (full) begin
			full_stalls++;
			@(posedge clk);
		end
		decode_char(c, last);
		chars_sent++;
	endtask

	// Stop sending and wait until every predicted result has been popped.
	task automatic wait_drained();
		@(negedge clk);
		push <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_alphabet(logic sel);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= sel;
		@(negedge clk);
		cfg_we <= 1'b0;
		alpha_sel = sel;
	endtask

	function automatic logic [7:0] sextet_char(logic [5:0] v);
		if (v < 26)
			return 8'("A" + v);
		if (v < 52)
			return 8'("a" + v - 26);
		if (v < 62)
			return 8'("0" + v - 52);
		if (v == 6'd62)
			return (alpha_sel == b64d_pkg::ALPHA_URL) ? "-" : "+";
		return (alpha_sel == b64d_pkg::ALPHA_URL) ? "_" : "/";
	endfunction

	// Fill msg_chars with the unpadded encoding of n random bytes.
	task automatic encode_bytes(int n);
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		msg_chars.delete();
		for (int i = 0; i < n; i += 3) begin
			b0 = 8'($urandom);
			b1 = (i + 1 < n) ? 8'($urandom) : 8'h00;
			b2 = (i + 2 < n) ? 8'($urandom) : 8'h00;
			msg_chars.push_back(sextet_char(b0[7:2]));
			msg_chars.push_back(sextet_char({b0[1:0], b1[7:4]}));
			if (i + 1 < n)
				msg_chars.push_back(sextet_char({b1[3:0], b2[7:6]}));
			if (i + 2 < n)
				msg_chars.push_back(sextet_char(b2[5:0]));
		end
	endtask

	task automatic send_message();
		for (int i = 0; i < msg_chars.size(); i++)
			send_char(msg_chars[i], i == msg_chars.size() - 1);
	endtask

	// Mostly valid messages; the rest carry a bad character, a lone final
	// character, nonzero tail bits, or are plain noise.
	task automatic send_random_message();
		int kind;
		int n;
		int idx;
		logic [7:0] bad;
		kind = $urandom_range(0, 99);
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);
		if (kind < 70) begin
			encode_bytes(n);
			send_message();
		end else if (kind < 80) begin
			encode_bytes(n);
			case ($urandom_range(0, 3))
				0: bad = "=";
				1: bad = (alpha_sel == b64d_pkg::ALPHA_URL) ? "+" : "_";
				2: bad = (alpha_sel == b64d_pkg::ALPHA_URL) ? "/" : "-";
				default: bad = 8'($urandom_range(128, 255));
			endcase
			idx = $urandom_range(0, msg_chars.size() - 1);
			msg_chars[idx] = bad;
			send_message();
		end else if (kind < 87) begin
			encode_bytes(3 * $urandom_range(0, 2));
			msg_chars.push_back(sextet_char(6'($urandom)));
			send_message();
		end else if (kind < 94) begin
			if (n % 3 == 0)
				n++;
			encode_bytes(n);
			void'(msg_chars.pop_back());
			if (n % 3 == 1)
				msg_chars.push_back(sextet_char({2'($urandom), 4'($urandom_range(1, 15))}));
			else
				msg_chars.push_back(sextet_char({4'($urandom), 2'($urandom_range(1, 3))}));
			send_message();
		end else begin
			repeat ($urandom_range(1, 6))
				send_char(8'($urandom), $urandom_range(0, 3) == 0);
		end
	endtask

	// Receiver: random stalls, or a forced hold-off while hold_left counts down.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Compare every popped result with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result byte %02h valid %0b eom %0b status %0d",
					data_byte, byte_valid, end_of_message, status));
			end else begin
				oldest_result = pending_results.pop_front();
				if (data_byte !== oldest_result.data_byte)
					report_mismatch($sformatf("data_byte %02h, expected %02h",
						data_byte, oldest_result.data_byte));
				if (byte_valid !== oldest_result.byte_valid)
					report_mismatch($sformatf("byte_valid %0b, expected %0b",
						byte_valid, oldest_result.byte_valid));
				if (end_of_message !== oldest_result.end_of_message)
					report_mismatch($sformatf("end_of_message %0b, expected %0b",
						end_of_message, oldest_result.end_of_message));
				if (status !== oldest_result.status)
					report_mismatch($sformatf("status %0d, expected %s",
						status, oldest_result.status.name()));
			end
		end
	end

	// Hand-picked cases on the url-safe alphabet, which is the reset setting.
	task automatic test_directed_url();
		send_char("_", 1'b0);
		send_char("w", 1'b1);
		send_char("A", 1'b0);
		send_char("A", 1'b1);
		send_char("A", 1'b1);
		send_char("A", 1'b0);
		send_char("B", 1'b1);
		send_char(8'hFF, 1'b0);
		send_char("Z", 1'b0);
		send_char("a", 1'b1);
		send_char("=", 1'b1);
		send_char(8'h00, 1'b1);
		send_char("+", 1'b1);
		send_char("z", 1'b0);
		send_char("0", 1'b0);
		send_char("9", 1'b0);
		send_char("-", 1'b1);
		wait_drained();
	endtask

	// The standard alphabet swaps the two symbol characters.
	task automatic test_directed_standard();
		set_alphabet(b64d_pkg::ALPHA_STANDARD);
		send_char("+", 1'b0);
		send_char("/", 1'b1);
		send_char("-", 1'b1);
		send_char("_", 1'b1);
		send_char("/", 1'b0);
		send_char("w", 1'b1);
		wait_drained();
	endtask

	task automatic test_random_traffic(logic sel, int n_chars, int idle_pct, int stall_pct);
		int start;
		set_alphabet(sel);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		start = chars_sent;
		while (chars_sent - start < n_chars)
			send_random_message();
		wait_drained();
	endtask

	// Hold the receiver off while valid messages stream in, so the input backs up.
	task automatic test_full_queue();
		int start;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 300;
		start = chars_sent;
		while (chars_sent - start < 60) begin
			encode_bytes($urandom_range(1, 6));
			send_message();
		end
		wait_drained();
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_url();
		test_directed_standard();
		test_random_traffic(b64d_pkg::ALPHA_URL, 300, 0, 0);
		test_random_traffic(b64d_pkg::ALPHA_STANDARD, 250, 81, 0);
		test_random_traffic(b64d_pkg::ALPHA_URL, 250, 0, 81);
		test_random_traffic(b64d_pkg::ALPHA_STANDARD, 250, 23, 23);
		test_full_queue();
		wait_drained();

		$display("Sent %0d characters on both alphabets, popped %0d results (%0d errors).",
			chars_sent, results_seen, errors_flagged);
		$display("Covered four idle mixes and a receiver hold-off with %0d cycles of full input.",
			full_stalls);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
